FILE: src/dfr_pkg.sv
// dfr_pkg: shared types and constants of the delimited frame receiver
// no dependencies; used by the top level and its interfaces' users

package dfr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUNT,
    ST_TYPE,
    ST_DATA,
    ST_SEND
  } dfr_state_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } dfr_cmd_t;

  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CfgIndexW-1:0] CFG_START_CHAR = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_END_CHAR   = 1'b1;

  localparam logic [7:0] START_CHAR_RST = 8'd123;
  localparam logic [7:0] END_CHAR_RST   = 8'd125;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [3:0] payload_length;
    logic       last;
  } dfr_result_t;

endpackage

FILE: src/dfr_if.sv
// dfr_in_if and dfr_out_if: valid/ready channels of the frame receiver
// no dependencies

interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [3:0] payload_length;
  logic       last;

  modport source (output valid, frame_type, data_byte, byte_valid, payload_length, last,
                  input ready);
  modport sink   (input valid, frame_type, data_byte, byte_valid, payload_length, last,
                  output ready);
endinterface

FILE: src/delimited_frame_receiver.sv
// delimited_frame_receiver: start/end delimited frame parser with idle timeout
// depends on dfr_pkg and the channel interfaces in dfr_if.sv

// Each input item is a received byte or a timer tick. Bytes hunt for start_char, take the
// next byte as the frame type and store payload bytes in a MAX_PAYLOAD-entry synchronous
// memory until end_char. A tick that finds no byte since the previous tick ends the burst; if
// a completed frame is pending it is read back out of the memory, one result per payload byte
// (a single result for an empty payload). The memory's single read port is registered and
// gives one entry per cycle while the output is not stalled. No input item is accepted during
// delivery. The result sits in an output register, so input items keep flowing while the last
// result waits to be taken. The payload memory needs no clearing pass after reset.
module delimited_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dfr_in_if.sink                        in_chan,
  dfr_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [dfr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dfr_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  dfr_pkg::dfr_state_t  state_r, state_nxt;
  logic                 activity_r, activity_nxt;
  logic                 frame_ready_r, frame_ready_nxt;
  logic [7:0]           kind_r, kind_nxt;
  logic [CntW-1:0]      count_r, count_nxt;
  logic [CntW-1:0]      iss_r, iss_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [7:0]           start_char_r, end_char_r;
  logic                 out_valid_r, out_valid_nxt;
  dfr_pkg::dfr_result_t out_r, out_nxt;

  logic [7:0]           payload_mem [MAX_PAYLOAD];
  logic [7:0]           rd_data_r;

  logic in_acc, is_tick, out_free, out_load, rd_en, wr_en;
  logic [7:0] b;

  assign in_chan.ready = (state_r != dfr_pkg::ST_SEND);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_tick       = (in_chan.command == dfr_pkg::CMD_TICK);
  assign b             = in_chan.rx_byte;
  assign out_free      = !out_valid_r || out_chan.ready;

  // payload write: a data byte that is neither the end character nor an overflow
  assign wr_en = in_acc && !is_tick && (state_r == dfr_pkg::ST_DATA) && (b != end_char_r)
                 && (count_r < CntW'(MAX_PAYLOAD));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_mem[count_r[IdxW-1:0]] <= b;
    end
    if (rd_en) begin
      rd_data_r <= payload_mem[iss_r[IdxW-1:0]];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    activity_nxt    = activity_r;
    frame_ready_nxt = frame_ready_r;
    kind_nxt        = kind_r;
    count_nxt       = count_r;
    iss_nxt         = iss_r;
    rd_v_nxt        = rd_v_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_nxt         = out_r;
    out_load        = 1'b0;
    rd_en           = 1'b0;

    unique case (state_r)
      dfr_pkg::ST_SEND: begin
        if (count_r == '0) begin
          // empty payload: one result with no data byte
          out_load = out_free;
          if (out_load) begin
            out_nxt.frame_type     = kind_r;
            out_nxt.data_byte      = '0;
            out_nxt.byte_valid     = 1'b0;
            out_nxt.payload_length = '0;
            out_nxt.last           = 1'b1;
            state_nxt              = dfr_pkg::ST_IDLE;
          end
        end else begin
          out_load = rd_v_r && out_free;
          rd_en    = (iss_r < count_r) && (!rd_v_r || out_load);
          if (rd_en) begin
            iss_nxt  = iss_r + CntW'(1);
            rd_v_nxt = 1'b1;
          end else if (out_load) begin
            rd_v_nxt = 1'b0;
          end
          if (out_load) begin
            // rd_data_r holds entry iss_r-1, the last one read
            out_nxt.frame_type     = kind_r;
            out_nxt.data_byte      = rd_data_r;
            out_nxt.byte_valid     = 1'b1;
            out_nxt.payload_length = 4'(count_r);
            out_nxt.last           = (iss_r == count_r);
            if (iss_r == count_r) begin
              state_nxt = dfr_pkg::ST_IDLE;
              count_nxt = '0;
              iss_nxt   = '0;
              rd_v_nxt  = 1'b0;
            end
          end
        end
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        if (in_acc && is_tick) begin
          if (state_r != dfr_pkg::ST_IDLE) begin
            if (activity_r) begin
              activity_nxt = 1'b0;
            end else if (frame_ready_r) begin
              state_nxt       = dfr_pkg::ST_SEND;
              frame_ready_nxt = 1'b0;
              iss_nxt         = '0;
              rd_v_nxt        = 1'b0;
            end else begin
              state_nxt = dfr_pkg::ST_IDLE;
              count_nxt = '0;
            end
          end
        end else if (in_acc) begin
          activity_nxt = 1'b1;
          unique case (state_r)
            dfr_pkg::ST_IDLE, dfr_pkg::ST_HUNT: begin
              state_nxt = dfr_pkg::ST_HUNT;
              if (b == start_char_r) begin
                state_nxt       = dfr_pkg::ST_TYPE;
                count_nxt       = '0;
                frame_ready_nxt = 1'b0;
              end
            end
            dfr_pkg::ST_TYPE: begin
              kind_nxt  = b;
              state_nxt = dfr_pkg::ST_DATA;
            end
            dfr_pkg::ST_DATA: begin
              if (b == end_char_r) begin
                state_nxt       = dfr_pkg::ST_HUNT;
                frame_ready_nxt = 1'b1;
              end else if (count_r < CntW'(MAX_PAYLOAD)) begin
                count_nxt = count_r + CntW'(1);
              end else begin
                // overflow drops the frame
                count_nxt = '0;
                state_nxt = dfr_pkg::ST_HUNT;
              end
            end
            default: begin
              state_nxt = state_r;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dfr_pkg::ST_IDLE;
      activity_r    <= 1'b0;
      frame_ready_r <= 1'b0;
      kind_r        <= '0;
      count_r       <= '0;
      iss_r         <= '0;
      rd_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      start_char_r  <= dfr_pkg::START_CHAR_RST;
      end_char_r    <= dfr_pkg::END_CHAR_RST;
    end else begin
      state_r       <= state_nxt;
      activity_r    <= activity_nxt;
      frame_ready_r <= frame_ready_nxt;
      kind_r        <= kind_nxt;
      count_r       <= count_nxt;
      iss_r         <= iss_nxt;
      rd_v_r        <= rd_v_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dfr_pkg::CFG_START_CHAR: start_char_r <= cfg_wdata;
          dfr_pkg::CFG_END_CHAR:   end_char_r   <= cfg_wdata;
          default:                 start_char_r <= start_char_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.frame_type     = out_r.frame_type;
  assign out_chan.data_byte      = out_r.data_byte;
  assign out_chan.byte_valid     = out_r.byte_valid;
  assign out_chan.payload_length = out_r.payload_length;
  assign out_chan.last           = out_r.last;

endmodule

FILE: src/dfr_checker.sv
// dfr_checker: port-level checks of the frame receiver, bound to the top level
// depends on delimited_frame_receiver and its channel interfaces

module dfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic [3:0] out_payload_length,
  input logic       out_last
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_byte) && $stable(out_last))
    else $error("stalled result changed");

  // inside a run no new item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("item accepted in the middle of a run");

  // an empty payload is a single closing result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && (out_payload_length == 4'd0))
    else $error("empty payload result malformed");

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_data_byte      (out_chan.data_byte),
  .out_byte_valid     (out_chan.byte_valid),
  .out_payload_length (out_chan.payload_length),
  .out_last           (out_chan.last)
);

FILE: tb/frame_delivery_checker.sv
`timescale 1ns / 100ps
// frame_delivery_checker: predicts the frame results of delimited_frame_receiver from the
// accepted items and register writes, and compares every result taken from the block
// depends on dfr_pkg

module frame_delivery_checker #(
  parameter int unsigned MAX_PAYLOAD = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_command,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_frame_type,
  input  logic [7:0]                    out_data_byte,
  input  logic                          out_byte_valid,
  input  logic [3:0]                    out_payload_length,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [dfr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dfr_pkg::CfgDataW-1:0]  cfg_wdata,
  output int                            fail_count,
  output int                            pending
);

  logic [7:0]          start_char_q;
  logic [7:0]          end_char_q;
  dfr_pkg::dfr_state_t rx_mode_q;
  bit                  activity_q;
  bit                  frame_done_q;
  logic [7:0]          frame_kind_q;
  int unsigned         payload_cnt_q;
  logic [7:0]          payload_mem [MAX_PAYLOAD];

  dfr_pkg::dfr_result_t expected_results[$];
  int                   errors;

  task automatic open_frame();
    rx_mode_q     = dfr_pkg::ST_TYPE;
    payload_cnt_q = 0;
    frame_done_q  = 0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    activity_q = 1;
    case (rx_mode_q)
      dfr_pkg::ST_IDLE: begin
        rx_mode_q = dfr_pkg::ST_HUNT;
        if (b == start_char_q) open_frame();
      end
      dfr_pkg::ST_HUNT: begin
        if (b == start_char_q) open_frame();
      end
      dfr_pkg::ST_TYPE: begin
        frame_kind_q = b;
        rx_mode_q    = dfr_pkg::ST_DATA;
      end
      default: begin
        // end char wins even when it equals the start char
        if (b == end_char_q) begin
          rx_mode_q    = dfr_pkg::ST_HUNT;
          frame_done_q = 1;
        end else if (payload_cnt_q < MAX_PAYLOAD) begin
          payload_mem[payload_cnt_q] = b;
          payload_cnt_q++;
        end else begin
          payload_cnt_q = 0;
          rx_mode_q     = dfr_pkg::ST_HUNT;
        end
      end
    endcase
  endtask

  task automatic absorb_tick();
    dfr_pkg::dfr_result_t r;
    int unsigned len;
    if (rx_mode_q == dfr_pkg::ST_IDLE) return;
    if (activity_q) begin
      activity_q = 0;
      return;
    end
    rx_mode_q = dfr_pkg::ST_IDLE;
    if (frame_done_q) begin
      len = (payload_cnt_q > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_cnt_q;
      if (len == 0) begin
        r.frame_type     = frame_kind_q;
        r.data_byte      = 8'h00;
        r.byte_valid     = 1'b0;
        r.payload_length = 4'd0;
        r.last           = 1'b1;
        expected_results.push_back(r);
      end else begin
        for (int unsigned i = 0; i < len; i++) begin
          r.frame_type     = frame_kind_q;
          r.data_byte      = payload_mem[i];
          r.byte_valid     = 1'b1;
          r.payload_length = 4'(len);
          r.last           = (i + 1 == len);
          expected_results.push_back(r);
        end
      end
    end
    frame_done_q  = 0;
    payload_cnt_q = 0;
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    dfr_pkg::dfr_result_t exp_r;
    if (!rst_n) begin
      start_char_q  = dfr_pkg::START_CHAR_RST;
      end_char_q    = dfr_pkg::END_CHAR_RST;
      rx_mode_q     = dfr_pkg::ST_IDLE;
      activity_q    = 0;
      frame_done_q  = 0;
      frame_kind_q  = 8'h00;
      payload_cnt_q = 0;
      for (int i = 0; i < MAX_PAYLOAD; i++) payload_mem[i] = 8'h00;
      expected_results.delete();
      errors = 0;
    end else begin
      // compare first: a result here can never come from an item taken at this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual type %0h byte %0h",
                   $realtime, out_frame_type, out_data_byte);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("frame_type", exp_r.frame_type, out_frame_type);
          check_field("data_byte", exp_r.data_byte, out_data_byte);
          check_field("byte_valid", exp_r.byte_valid, out_byte_valid);
          check_field("payload_length", exp_r.payload_length, out_payload_length);
          check_field("last", exp_r.last, out_last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          dfr_pkg::CFG_START_CHAR: start_char_q = cfg_wdata;
          dfr_pkg::CFG_END_CHAR:   end_char_q   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_command == dfr_pkg::CMD_TICK) absorb_tick();
        else absorb_byte(in_rx_byte);
      end
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

FILE: tb/tb_delimited_frame_receiver.sv
`timescale 1ns / 100ps
// tb_delimited_frame_receiver: drives bytes, ticks and register writes into
// delimited_frame_receiver and gives the verdict; depends on dfr_pkg, dfr_if.sv
// and frame_delivery_checker

module tb_delimited_frame_receiver;

  localparam int unsigned MaxPayload = 10;
  localparam int          CycleLimit = 200000;
  localparam int          RandomPerPhase = 76;

  logic clk = 1'b0;
  logic rst_n;
  logic                          cfg_we;
  logic [dfr_pkg::CfgIndexW-1:0] cfg_index;
  logic [dfr_pkg::CfgDataW-1:0]  cfg_wdata;

  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  int random_items = 0;
  logic [7:0] cur_start = dfr_pkg::START_CHAR_RST;
  logic [7:0] cur_end   = dfr_pkg::END_CHAR_RST;

  dfr_in_if  in_chan ();
  dfr_out_if out_chan ();

  delimited_frame_receiver #(.MAX_PAYLOAD(MaxPayload)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  frame_delivery_checker #(.MAX_PAYLOAD(MaxPayload)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_command        (in_chan.command),
    .in_rx_byte        (in_chan.rx_byte),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_frame_type    (out_chan.frame_type),
    .out_data_byte     (out_chan.data_byte),
    .out_byte_valid    (out_chan.byte_valid),
    .out_payload_length(out_chan.payload_length),
    .out_last          (out_chan.last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver back-pressure in one of four styles, redrawn at random
  initial begin
    int style;
    int hold;
    int cnt;
    style = 0;
    hold  = 0;
    cnt   = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cnt++;
      if (cnt % 128 == 0) style = $urandom_range(0, 3);
      case (style)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= 1'($urandom);
        2: out_chan.ready <= (cnt % 4 == 0);
        default: begin
          // long stalls broken by short ready windows
          if (hold == 0) hold = $urandom_range(1, 16);
          hold--;
          out_chan.ready <= (hold < 3);
        end
      endcase
    end
  end

  task automatic send_item(input dfr_pkg::dfr_cmd_t cmd, input logic [7:0] b,
                           input bit counted);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid   <= 1'b1;
    in_chan.command <= cmd;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    burst_left--;
    if (counted) random_items++;
  endtask

  // hold the sender until every expected result has been taken
  task automatic quiesce();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_chars(input logic [7:0] s, input logic [7:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= dfr_pkg::CFG_START_CHAR;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= dfr_pkg::CFG_END_CHAR;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_start = s;
    cur_end   = e;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == x) v = 8'($urandom);
    return v;
  endfunction

  task automatic send_frame();
    int style;
    int len;
    style = $urandom_range(0, 15);
    if (style == 0) begin
      repeat ($urandom_range(1, 4)) send_item(dfr_pkg::CMD_BYTE, 8'($urandom), 1'b1);
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(dfr_pkg::CMD_BYTE, other_than(cur_start), 1'b1);
      end
      send_item(dfr_pkg::CMD_BYTE, cur_start, 1'b1);
      send_item(dfr_pkg::CMD_BYTE, 8'($urandom), 1'b1);
      len = ($urandom_range(0, 11) == 0) ? MaxPayload + 1 : $urandom_range(0, MaxPayload);
      for (int i = 0; i < len; i++) begin
        // a tick right after a byte only clears the activity mark
        if ($urandom_range(0, 9) == 0) send_item(dfr_pkg::CMD_TICK, 8'($urandom), 1'b1);
        send_item(dfr_pkg::CMD_BYTE, other_than(cur_end), 1'b1);
      end
      // style 1 leaves the frame open so the timeout drops it
      if (len <= MaxPayload && style != 1) send_item(dfr_pkg::CMD_BYTE, cur_end, 1'b1);
      case (style)
        2: send_item(dfr_pkg::CMD_BYTE, other_than(cur_start), 1'b1);
        3: begin
          send_item(dfr_pkg::CMD_BYTE, cur_start, 1'b1);
          send_item(dfr_pkg::CMD_BYTE, 8'($urandom), 1'b1);
          send_item(dfr_pkg::CMD_BYTE, other_than(cur_end), 1'b1);
          send_item(dfr_pkg::CMD_BYTE, cur_end, 1'b1);
        end
        default: ;
      endcase
    end
    send_item(dfr_pkg::CMD_TICK, 8'($urandom), 1'b1);
    send_item(dfr_pkg::CMD_TICK, 8'($urandom), 1'b1);
    if ($urandom_range(0, 4) == 0) send_item(dfr_pkg::CMD_TICK, 8'($urandom), 1'b0);
    if ($urandom_range(0, 19) == 0) quiesce();
  endtask

  task automatic run_random(input int count);
    int target;
    target = random_items + count;
    while (random_items < target) send_frame();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.command <= dfr_pkg::CMD_BYTE;
    in_chan.rx_byte <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_index       <= dfr_pkg::CFG_START_CHAR;
    cfg_wdata       <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick while idle
    send_item(dfr_pkg::CMD_TICK, 8'hFF, 1'b0);
    // start from idle, extreme type and payload, stray byte after the end char
    send_item(dfr_pkg::CMD_BYTE, dfr_pkg::START_CHAR_RST, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, 8'hFF, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, 8'h00, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, 8'hFF, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, dfr_pkg::END_CHAR_RST, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, 8'h55, 1'b0);
    send_item(dfr_pkg::CMD_TICK, 8'h00, 1'b0);
    send_item(dfr_pkg::CMD_TICK, 8'h00, 1'b0);
    // completed frame cancelled by a new start, then an empty payload
    send_item(dfr_pkg::CMD_BYTE, dfr_pkg::START_CHAR_RST, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, 8'h00, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, dfr_pkg::END_CHAR_RST, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, dfr_pkg::START_CHAR_RST, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, 8'h00, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, dfr_pkg::END_CHAR_RST, 1'b0);
    send_item(dfr_pkg::CMD_TICK, 8'h00, 1'b0);
    send_item(dfr_pkg::CMD_TICK, 8'h00, 1'b0);
    // hunt byte, then a payload one byte too long, then timeout with nothing pending
    send_item(dfr_pkg::CMD_BYTE, 8'h7A, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, dfr_pkg::START_CHAR_RST, 1'b0);
    send_item(dfr_pkg::CMD_BYTE, 8'h07, 1'b0);
    for (int i = 0; i <= MaxPayload; i++) send_item(dfr_pkg::CMD_BYTE, 8'(i + 1), 1'b0);
    send_item(dfr_pkg::CMD_TICK, 8'h00, 1'b0);
    send_item(dfr_pkg::CMD_TICK, 8'h00, 1'b0);

    run_random(RandomPerPhase);
    quiesce();
    set_chars(8'h00, 8'hFF);
    run_random(RandomPerPhase);
    quiesce();
    set_chars(8'hFF, 8'hFF);
    run_random(RandomPerPhase);
    quiesce();
    set_chars(8'($urandom), 8'($urandom));
    run_random(RandomPerPhase);
    quiesce();
    set_chars(8'hFF, 8'h00);
    run_random(RandomPerPhase);

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
